@@ design/are_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP resolve engine package
// Field widths, result kinds, ARP opcodes, record types and controller states.
// ----------------------------------------------------------------------------
package are_pkg;

  localparam int KIND_W = 2;
  localparam int PORT_W = 2;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TAG_W  = 16;
  localparam int LEN_W  = 16;
  localparam int OP_W   = 16;

  localparam logic [KIND_W-1:0] KIND_FWD       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARP_REQ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ARP_REPLY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROP      = 2'd3;

  localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
  localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

  localparam logic REQ_OUTGOING = 1'b0;

  localparam logic [7:0] BCAST_BYTE = 8'd255;
  localparam logic [MAC_W-1:0] BCAST_MAC = {6{BCAST_BYTE}};

  // Releases per received reply are capped at this many results.
  localparam int MAX_RESULTS = 32;
  localparam int REL_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic [TAG_W-1:0]  tag;
    logic [IP_W-1:0]   ip;
  } pend_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_RESOLVE,
    ST_FINAL,
    ST_REL_RD,
    ST_REL_CHK,
    ST_REL_END
  } state_t;

endpackage

@@ design/arp_resolve_engine_core.sv @@
// ----------------------------------------------------------------------------
// ARP resolve engine
// IP-to-MAC table with a queue of packet descriptors awaiting resolution.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one item per outgoing packet (tuser low) or per
// received ARP packet (tuser high). The out_ channel carries forward, ARP
// request, ARP reply and drop items; tlast marks the last item caused by an
// input item. An input that causes nothing produces no output item.
// Items are handled one at a time. The table is searched one entry at a time
// in a memory, each entry read and then compared. A received ARP reply that
// updates or adds a table entry then walks the pending queue memory
// descriptor by descriptor and emits one forward item per match.
// Received ARP requests and outgoing packets on a bad port skip the search.
// The result sits in an output register, so the next item is taken while the
// last result still waits; a stalled receiver holds the walk only when a
// second result is ready. Reset empties the table and the queue at once
// (counts cleared, no memory sweep).
module arp_resolve_engine_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int QUEUE_DEPTH = 32,
  parameter int PORTS       = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // arp_op[15:0], ip_addr[47:16], hw_addr[95:48], port_num[97:96],
  // packet_tag[113:98], pkt_bytes[129:114], zero fill above
  input  logic [135:0] in_tdata,
  // req_type
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_kind[1:0], out_port[3:2], dest_hw_addr[51:4], target_ip[83:52],
  // out_tag[99:84], out_len[115:100], zero fill above
  output logic [119:0] out_tdata,
  output logic         out_tlast
);

  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // Input field unpacking.
  logic [are_pkg::OP_W-1:0]   in_op;
  logic [are_pkg::IP_W-1:0]   in_ip;
  logic [are_pkg::MAC_W-1:0]  in_mac;
  logic [are_pkg::PORT_W-1:0] in_port;
  logic [are_pkg::TAG_W-1:0]  in_tag;
  logic [are_pkg::LEN_W-1:0]  in_len;
  logic                       in_port_bad;

  assign in_op       = in_tdata[15:0];
  assign in_ip       = in_tdata[47:16];
  assign in_mac      = in_tdata[95:48];
  assign in_port     = in_tdata[97:96];
  assign in_tag      = in_tdata[113:98];
  assign in_len      = in_tdata[129:114];
  assign in_port_bad = 32'(in_port) >= PORTS;

  // Control state.
  are_pkg::state_t         state_r, state_nxt;
  logic [TCW-1:0]          tcount_r, tcount_nxt;
  logic [QCW-1:0]          pcount_r, pcount_nxt;
  logic [TCW-1:0]          sidx_r, sidx_nxt;
  logic                    hit_r, hit_nxt;
  logic [QCW-1:0]          ridx_r, ridx_nxt;
  logic [QCW-1:0]          keep_r, keep_nxt;
  logic [are_pkg::REL_CNT_W-1:0] nrel_r, nrel_nxt;
  logic                    hld_vld_r, hld_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;

  // Payload registers.
  logic                       cur_req_r;
  logic [are_pkg::IP_W-1:0]   cur_ip_r;
  logic [are_pkg::MAC_W-1:0]  cur_mac_r;
  logic [are_pkg::PORT_W-1:0] cur_port_r;
  logic [are_pkg::TAG_W-1:0]  cur_tag_r;
  logic [are_pkg::LEN_W-1:0]  cur_len_r;
  logic [are_pkg::MAC_W-1:0]  hit_mac_r;
  are_pkg::result_t           res_r, res_nxt;
  are_pkg::result_t           out_r;
  logic                       out_last_r, out_last_nxt;

  logic cur_load, hit_load, res_load, out_load;

  // Memories.
  logic                      tbl_ip_we, tbl_mac_we;
  logic [TAW-1:0]            tbl_waddr, tbl_raddr;
  logic [are_pkg::IP_W-1:0]  tbl_ip_rd;
  logic [are_pkg::MAC_W-1:0] tbl_mac_rd;
  logic                      pq_we;
  logic [QAW-1:0]            pq_waddr, pq_raddr;
  are_pkg::pend_t            pq_wdata, pq_rd;

  logic out_free;
  logic rel_match;

  assign out_free  = !out_vld_r || out_tready;
  assign rel_match = (pq_rd.ip == cur_ip_r) &&
                     (nrel_r < are_pkg::REL_CNT_W'(are_pkg::MAX_RESULTS));
  assign tbl_raddr = sidx_r[TAW-1:0];
  assign pq_raddr  = ridx_r[QAW-1:0];

  are_ram #(.WIDTH(are_pkg::IP_W), .DEPTH(TABLE_DEPTH)) u_tbl_ip (
    .clk   (clk),
    .we    (tbl_ip_we),
    .waddr (tbl_waddr),
    .wdata (cur_ip_r),
    .raddr (tbl_raddr),
    .rdata (tbl_ip_rd)
  );

  are_ram #(.WIDTH(are_pkg::MAC_W), .DEPTH(TABLE_DEPTH)) u_tbl_mac (
    .clk   (clk),
    .we    (tbl_mac_we),
    .waddr (tbl_waddr),
    .wdata (cur_mac_r),
    .raddr (tbl_raddr),
    .rdata (tbl_mac_rd)
  );

  are_ram #(.WIDTH($bits(are_pkg::pend_t)), .DEPTH(QUEUE_DEPTH)) u_pend (
    .clk   (clk),
    .we    (pq_we),
    .waddr (pq_waddr),
    .wdata (pq_wdata),
    .raddr (pq_raddr),
    .rdata (pq_rd)
  );

  always_comb begin
    state_nxt    = state_r;
    tcount_nxt   = tcount_r;
    pcount_nxt   = pcount_r;
    sidx_nxt     = sidx_r;
    hit_nxt      = hit_r;
    ridx_nxt     = ridx_r;
    keep_nxt     = keep_r;
    nrel_nxt     = nrel_r;
    hld_vld_nxt  = hld_vld_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_last_nxt = out_last_r;
    res_nxt      = res_r;
    cur_load     = 1'b0;
    hit_load     = 1'b0;
    res_load     = 1'b0;
    out_load     = 1'b0;
    tbl_ip_we    = 1'b0;
    tbl_mac_we   = 1'b0;
    tbl_waddr    = tcount_r[TAW-1:0];
    pq_we        = 1'b0;
    pq_waddr     = pcount_r[QAW-1:0];
    pq_wdata     = '{port: cur_port_r, len: cur_len_r, tag: cur_tag_r, ip: cur_ip_r};
    in_tready    = (state_r == are_pkg::ST_IDLE);

    unique case (state_r)
      are_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cur_load = 1'b1;
          sidx_nxt = '0;
          if (in_tuser == are_pkg::REQ_OUTGOING) begin
            if (in_port_bad) begin
              res_load  = 1'b1;
              res_nxt   = '{kind: are_pkg::KIND_DROP, port: in_port, mac: '0,
                            ip: in_ip, tag: in_tag, len: in_len};
              state_nxt = are_pkg::ST_FINAL;
            end else begin
              state_nxt = are_pkg::ST_SRCH_RD;
            end
          end else if (!in_port_bad) begin
            if (in_op == are_pkg::OP_REQUEST) begin
              res_load  = 1'b1;
              res_nxt   = '{kind: are_pkg::KIND_ARP_REPLY, port: in_port, mac: in_mac,
                            ip: in_ip, tag: '0, len: '0};
              state_nxt = are_pkg::ST_FINAL;
            end else if (in_op == are_pkg::OP_REPLY) begin
              state_nxt = are_pkg::ST_SRCH_RD;
            end
          end
        end
      end

      are_pkg::ST_SRCH_RD: begin
        if (sidx_r >= tcount_r) begin
          hit_nxt   = 1'b0;
          state_nxt = are_pkg::ST_RESOLVE;
        end else begin
          state_nxt = are_pkg::ST_SRCH_CHK;
        end
      end

      are_pkg::ST_SRCH_CHK: begin
        if (tbl_ip_rd == cur_ip_r) begin
          hit_nxt   = 1'b1;
          hit_load  = 1'b1;
          state_nxt = are_pkg::ST_RESOLVE;
        end else begin
          sidx_nxt  = sidx_r + TCW'(1);
          state_nxt = are_pkg::ST_SRCH_RD;
        end
      end

      are_pkg::ST_RESOLVE: begin
        res_load  = 1'b1;
        state_nxt = are_pkg::ST_FINAL;
        if (cur_req_r == are_pkg::REQ_OUTGOING) begin
          if (hit_r) begin
            res_nxt = '{kind: are_pkg::KIND_FWD, port: cur_port_r, mac: hit_mac_r,
                        ip: cur_ip_r, tag: cur_tag_r, len: cur_len_r};
          end else if (pcount_r >= QCW'(QUEUE_DEPTH)) begin
            res_nxt = '{kind: are_pkg::KIND_DROP, port: cur_port_r, mac: '0,
                        ip: cur_ip_r, tag: cur_tag_r, len: cur_len_r};
          end else begin
            pq_we      = 1'b1;
            pcount_nxt = pcount_r + QCW'(1);
            res_nxt    = '{kind: are_pkg::KIND_ARP_REQ, port: cur_port_r,
                           mac: are_pkg::BCAST_MAC, ip: cur_ip_r, tag: '0, len: '0};
          end
        end else begin
          // Received reply: learn (if the table has room) or update, then release matching descriptors.
          // Only descriptors with this IP can become resolvable here.
          res_load    = 1'b0;
          ridx_nxt    = '0;
          keep_nxt    = '0;
          nrel_nxt    = '0;
          hld_vld_nxt = 1'b0;
          state_nxt   = are_pkg::ST_IDLE;
          if (hit_r) begin
            tbl_waddr  = sidx_r[TAW-1:0];
            tbl_mac_we = 1'b1;
            if (pcount_r != '0) begin
              state_nxt = are_pkg::ST_REL_RD;
            end
          end else if (tcount_r < TCW'(TABLE_DEPTH)) begin
            tbl_ip_we  = 1'b1;
            tbl_mac_we = 1'b1;
            tcount_nxt = tcount_r + TCW'(1);
            if (pcount_r != '0) begin
              state_nxt = are_pkg::ST_REL_RD;
            end
          end
        end
      end

      are_pkg::ST_FINAL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = are_pkg::ST_IDLE;
        end
      end

      are_pkg::ST_REL_RD: begin
        state_nxt = are_pkg::ST_REL_CHK;
      end

      are_pkg::ST_REL_CHK: begin
        if (!(rel_match && hld_vld_r && !out_free)) begin
          if (rel_match) begin
            if (hld_vld_r) begin
              out_load     = 1'b1;
              out_vld_nxt  = 1'b1;
              out_last_nxt = 1'b0;
            end
            res_load    = 1'b1;
            res_nxt     = '{kind: are_pkg::KIND_FWD, port: pq_rd.port, mac: cur_mac_r,
                            ip: pq_rd.ip, tag: pq_rd.tag, len: pq_rd.len};
            hld_vld_nxt = 1'b1;
            nrel_nxt    = nrel_r + are_pkg::REL_CNT_W'(1);
          end else begin
            // Compaction: the write index never passes the read index.
            pq_we    = 1'b1;
            pq_waddr = keep_r[QAW-1:0];
            pq_wdata = pq_rd;
            keep_nxt = keep_r + QCW'(1);
          end
          ridx_nxt = ridx_r + QCW'(1);
          if (ridx_r + QCW'(1) >= pcount_r) begin
            state_nxt = are_pkg::ST_REL_END;
          end else begin
            state_nxt = are_pkg::ST_REL_RD;
          end
        end
      end

      are_pkg::ST_REL_END: begin
        if (!hld_vld_r) begin
          pcount_nxt = keep_r;
          state_nxt  = are_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          hld_vld_nxt  = 1'b0;
          pcount_nxt   = keep_r;
          state_nxt    = are_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = are_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= are_pkg::ST_IDLE;
      tcount_r  <= '0;
      pcount_r  <= '0;
      sidx_r    <= '0;
      hit_r     <= 1'b0;
      ridx_r    <= '0;
      keep_r    <= '0;
      nrel_r    <= '0;
      hld_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tcount_r  <= tcount_nxt;
      pcount_r  <= pcount_nxt;
      sidx_r    <= sidx_nxt;
      hit_r     <= hit_nxt;
      ridx_r    <= ridx_nxt;
      keep_r    <= keep_nxt;
      nrel_r    <= nrel_nxt;
      hld_vld_r <= hld_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_req_r  <= in_tuser;
      cur_ip_r   <= in_ip;
      cur_mac_r  <= in_mac;
      cur_port_r <= in_port;
      cur_tag_r  <= in_tag;
      cur_len_r  <= in_len;
    end
    if (hit_load) begin
      hit_mac_r <= tbl_mac_rd;
    end
    if (out_load) begin
      out_r      <= res_r;
      out_last_r <= out_last_nxt;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_r.len, out_r.tag, out_r.ip, out_r.mac,
                       out_r.port, out_r.kind};

endmodule

@@ design/are_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module are_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
